// ----- hdl/isu_pkg.sv -----
// Package for the indexed sequence store: widths, capacity, opcodes,
// status codes and the control word broadcast to the cell row. No dependencies.
`default_nettype none

package isu_pkg;

  localparam int CAPACITY = 256;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 9;
  localparam int CNT_W    = 9;

  // read tree: cells are OR-reduced in groups, group results are registered
  localparam int GROUP    = 16;
  localparam int NGROUP   = (CAPACITY + GROUP - 1) / GROUP;

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_APPEND = 2'd2,
    KIND_DELETE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // broadcast to every cell in the row
  typedef struct packed {
    logic              ins;    // shift up from pos, load value at pos
    logic              del;    // shift down into pos
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/isu_in_if.sv -----
// Request channel of the indexed sequence store: valid/ready plus item payload.
// Depends on isu_pkg.
`default_nettype none

interface isu_in_if
  import isu_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output kind, output position, output value, input ready);
  modport sink   (input valid, input kind, input position, input value, output ready);
endinterface

`default_nettype wire

// ----- hdl/isu_out_if.sv -----
// Result channel of the indexed sequence store: valid/ready plus result payload.
// Depends on isu_pkg.
`default_nettype none

interface isu_out_if
  import isu_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_value;
  logic [1:0]               status;
  logic [CNT_W-1:0]         element_count;

  modport source (output valid, output read_value, output status, output element_count,
                  input ready);
  modport sink   (input valid, input read_value, input status, input element_count,
                  output ready);
endinterface

`default_nettype wire

// ----- hdl/isu_cell.sv -----
// One positional cell of the sequence row: holds one element, takes from its
// left or right neighbor on insert/delete. Depends on isu_pkg.
`default_nettype none

module isu_cell
  import isu_pkg::*;
(
  input  wire                     clk_i,
  input  wire cell_ctrl_t         ctrl_i,
  input  wire logic [POS_W-1:0]   idx_i,
  input  wire logic [DATA_W-1:0]  left_i,
  input  wire logic [DATA_W-1:0]  right_i,
  output logic      [DATA_W-1:0]  value_o,
  output logic      [DATA_W-1:0]  rd_o
);

  logic [DATA_W-1:0] val_q, val_d;
  logic              hit, above;

  assign hit   = (idx_i == ctrl_i.pos);
  assign above = (idx_i > ctrl_i.pos);

  always_comb begin
    val_d = val_q;
    if (ctrl_i.ins) begin
      if (above)    val_d = left_i;
      else if (hit) val_d = ctrl_i.value;
    end else if (ctrl_i.del) begin
      if (hit || above) val_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign value_o = val_q;
  // only the addressed cell drives the read tree
  assign rd_o    = hit ? val_q : '0;

endmodule

`default_nettype wire

// ----- hdl/isu_rd_tree.sv -----
// Two-level OR tree collecting the addressed cell's value; the group level
// is registered. Depends on isu_pkg.
`default_nettype none

module isu_rd_tree
  import isu_pkg::*;
(
  input  wire                    clk_i,
  input  wire logic              load_i,
  input  wire logic [DATA_W-1:0] rd_i [CAPACITY],
  output logic      [DATA_W-1:0] data_o
);

  logic [DATA_W-1:0] grp_d [NGROUP];
  logic [DATA_W-1:0] grp_q [NGROUP];

  always_comb begin
    for (int k = 0; k < NGROUP; k++) begin
      grp_d[k] = '0;
      for (int j = 0; j < GROUP; j++) begin
        if (k * GROUP + j < CAPACITY) grp_d[k] = grp_d[k] | rd_i[k * GROUP + j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int k = 0; k < NGROUP; k++) grp_q[k] <= grp_d[k];
    end
  end

  always_comb begin
    data_o = '0;
    for (int k = 0; k < NGROUP; k++) data_o = data_o | grp_q[k];
  end

endmodule

`default_nettype wire

// ----- hdl/indexed_sequence_store_unit.sv -----
// Indexed sequence store: an ordered list of up to CAPACITY (256) signed
// 32-bit elements held in a row of positional cells, cell 0 being the head.
// Depends on isu_pkg, isu_in_if, isu_out_if, isu_cell and isu_rd_tree.
//
// Each request item is one of read, insert-before, append or delete and
// yields exactly one result item with the read data (-1 unless a read hit),
// a status (done, position out of range, full) and the element count after
// the operation. Insert and delete move every cell at or above the position
// at once, each cell taking its neighbor's value, so they finish at the
// clock edge that accepts the item. Reads pass through a two-level OR tree
// whose group level is registered: the read data is ready in the cycle after
// acceptance. Insert, append and delete results (refused or not) pass from
// the holding stage into the output register, and the next item can be taken
// as each result moves on, so those run at one item per cycle while the
// output register is free or being drained; every read, hit or miss, waits in
// the holding stage for the tree's group registers, blocking the next accept.
// A finished result sits in a holding stage and then in the output register,
// so a stalled consumer does not block the next accept until both are
// occupied. Cell contents are not reset; only positions below the count are
// ever read. There is no clearing pass after reset.
`default_nettype none

module indexed_sequence_store_unit
  import isu_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  isu_in_if.sink       in_i,
  isu_out_if.source    out_o
);

  // ---------------------------------------------------------------------------
  // Cell row
  // ---------------------------------------------------------------------------
  cell_ctrl_t        ctrl;
  logic [DATA_W-1:0] cell_val [CAPACITY];
  logic [DATA_W-1:0] cell_rd  [CAPACITY];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam logic [POS_W-1:0] IDX = POS_W'(g);
    logic [DATA_W-1:0] left_val, right_val;

    if (g == 0) begin : g_head
      assign left_val = '0;
    end else begin : g_mid_l
      assign left_val = cell_val[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_val = '0;
    end else begin : g_mid_r
      assign right_val = cell_val[g+1];
    end

    isu_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .idx_i   (IDX),
      .left_i  (left_val),
      .right_i (right_val),
      .value_o (cell_val[g]),
      .rd_o    (cell_rd[g])
    );
  end

  logic              tree_load;
  logic [DATA_W-1:0] tree_data;

  isu_rd_tree u_rd_tree (
    .clk_i  (clk_i),
    .load_i (tree_load),
    .rd_i   (cell_rd),
    .data_o (tree_data)
  );

  // ---------------------------------------------------------------------------
  // Operation decode at accept
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             accept;
  kind_e            kind;
  logic             full, pos_lt_cnt, pos_gt_cnt;
  status_e          st;
  logic             rd_ok;

  // holding stage for the result under construction
  logic             res_valid_q, res_valid_d;
  logic             res_wait_q,  res_wait_d;   // read data arrives from the tree
  logic             res_ok_q;                  // read hit
  status_e          res_st_q;
  logic [CNT_W-1:0] res_cnt_q;
  logic             res_move;

  // output register
  logic                     out_valid_q;
  logic [DATA_W-1:0]        out_rd_q;
  status_e                  out_st_q;
  logic [CNT_W-1:0]         out_cnt_q;

  assign kind       = kind_e'(in_i.kind);
  assign full       = (cnt_q == CNT_W'(CAPACITY));
  assign pos_lt_cnt = (in_i.position < cnt_q);
  assign pos_gt_cnt = (in_i.position > cnt_q);

  assign res_move  = res_valid_q && !res_wait_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !res_valid_q || res_move;
  assign accept    = in_i.valid && in_i.ready;

  always_comb begin
    ctrl.ins   = 1'b0;
    ctrl.del   = 1'b0;
    ctrl.pos   = in_i.position;
    ctrl.value = in_i.value;
    cnt_d      = cnt_q;
    st         = ST_DONE;
    rd_ok      = 1'b0;
    case (kind)
      KIND_READ: begin
        rd_ok = pos_lt_cnt;
        if (!pos_lt_cnt) st = ST_RANGE;
      end
      KIND_INSERT: begin
        if (pos_gt_cnt)  st = ST_RANGE;
        else if (full)   st = ST_FULL;
        else begin
          ctrl.ins = accept;
          if (accept) cnt_d = cnt_q + 1'b1;
        end
      end
      KIND_APPEND: begin
        ctrl.pos = cnt_q;
        if (full) st = ST_FULL;
        else begin
          ctrl.ins = accept;
          if (accept) cnt_d = cnt_q + 1'b1;
        end
      end
      KIND_DELETE: begin
        if (!pos_lt_cnt) st = ST_RANGE;
        else begin
          ctrl.del = accept;
          if (accept) cnt_d = cnt_q - 1'b1;
        end
      end
      default: st = ST_DONE;
    endcase
  end

  assign tree_load = accept && (kind == KIND_READ);

  // ---------------------------------------------------------------------------
  // Holding stage and output register
  // ---------------------------------------------------------------------------
  always_comb begin
    res_valid_d = res_valid_q;
    res_wait_d  = 1'b0;
    if (res_move)  res_valid_d = 1'b0;
    if (accept) begin
      res_valid_d = 1'b1;
      res_wait_d  = (kind == KIND_READ);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
      res_wait_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
      res_wait_q  <= res_wait_d;
      if (res_move)                out_valid_q <= 1'b1;
      else if (out_o.ready)        out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_ok_q  <= rd_ok;
      res_st_q  <= st;
      res_cnt_q <= cnt_d;
    end
    if (res_move) begin
      out_rd_q  <= res_ok_q ? tree_data : '1;
      out_st_q  <= res_st_q;
      out_cnt_q <= res_cnt_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.read_value    = out_rd_q;
  assign out_o.status        = out_st_q;
  assign out_o.element_count = out_cnt_q;

endmodule

`default_nettype wire

// ----- tb/tb_indexed_sequence_store_unit.sv -----
// Self-checking testbench for indexed_sequence_store_unit: list operations in,
// one status/count item out per request. Depends on isu_pkg, isu_in_if, isu_out_if.
module tb_indexed_sequence_store_unit;
  import isu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Worst case is about 800 items, each with a read's hold-up plus the longest
  // idle gap and stall burst, so this is many times the slowest passing run.
  localparam int CYCLE_LIMIT = 200000;

  // One item on the result channel, as the shadow list predicts it.
  typedef struct {
    logic signed [DATA_W-1:0] read_value;
    status_e                  status;
    logic [CNT_W-1:0]         element_count;
  } seq_outcome_t;

  logic clk_i;
  logic rst_ni;

  isu_in_if  in_if ();
  isu_out_if out_if ();

  indexed_sequence_store_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Shadow copy of the list: element 0 is the head.
  logic signed [DATA_W-1:0] shadow_cells[$];
  int                       shadow_count;

  // Outcomes of accepted requests, oldest first.
  seq_outcome_t op_outcome_q[$];

  int error_count;
  int cycle_count;
  bit send_idle_en;    // sender inserts random gaps
  bit ready_stall_en;  // receiver drops ready at random

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: watchdog expired, %0d outcomes still pending", $realtime,
               op_outcome_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Applies one request to the shadow list and returns what the unit must report.
  // Insert checks the range before the full condition, as the unit does.
  function automatic seq_outcome_t apply_seq_op(kind_e kind, logic [POS_W-1:0] pos,
                                                logic signed [DATA_W-1:0] val);
    seq_outcome_t res;
    res.read_value = -1;
    res.status     = ST_DONE;
    case (kind)
      KIND_READ: begin
        if (pos < shadow_count) res.read_value = shadow_cells[pos];
        else res.status = ST_RANGE;
      end
      KIND_INSERT: begin
        if (pos > shadow_count) res.status = ST_RANGE;
        else if (shadow_count >= CAPACITY) res.status = ST_FULL;
        else begin
          shadow_cells.insert(int'(pos), val);
          shadow_count++;
        end
      end
      KIND_APPEND: begin
        if (shadow_count >= CAPACITY) res.status = ST_FULL;
        else begin
          shadow_cells.push_back(val);
          shadow_count++;
        end
      end
      default: begin  // delete
        if (pos < shadow_count) begin
          shadow_cells.delete(int'(pos));
          shadow_count--;
        end else res.status = ST_RANGE;
      end
    endcase
    res.element_count = CNT_W'(shadow_count);
    return res;
  endfunction

  // Sends one request item. Called at a rising edge; returns at the edge that
  // accepted it, so the next call can keep valid high without a bubble.
  task automatic send_op(input kind_e kind, input logic [POS_W-1:0] pos,
                         input logic signed [DATA_W-1:0] val);
    if (send_idle_en && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.kind     <= kind;
    in_if.position <= pos;
    in_if.value    <= val;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    op_outcome_q.push_back(apply_seq_op(kind, pos, val));
  endtask

  // Holds the sender off until every pending outcome has come back.
  // At least one edge passes, so valid is never lowered and raised in one step.
  task automatic wait_for_outcomes();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (op_outcome_q.size() != 0);
  endtask

  // Receiver: ready high, with random stall bursts while enabled.
  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (ready_stall_en && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
    end
  end

  // Result checker: every accepted result item against the oldest outcome.
  always @(posedge clk_i) begin
    seq_outcome_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (op_outcome_q.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result: expected none, actual rd=%0d st=%0d cnt=%0d",
                 $realtime, out_if.read_value, out_if.status, out_if.element_count);
      end else begin
        want = op_outcome_q.pop_front();
        if (out_if.read_value !== want.read_value) begin
          error_count++;
          $display("%0t: read_value mismatch: expected %0d, actual %0d",
                   $realtime, want.read_value, out_if.read_value);
        end
        if (out_if.status !== want.status) begin
          error_count++;
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $realtime, want.status, out_if.status);
        end
        if (out_if.element_count !== want.element_count) begin
          error_count++;
          $display("%0t: element_count mismatch: expected %0d, actual %0d",
                   $realtime, want.element_count, out_if.element_count);
        end
      end
    end
  end

  // Empty list: every positional op misses, insert past the tail is refused.
  task automatic test_empty_store();
    send_op(KIND_READ,   9'd0,   $urandom);
    send_op(KIND_DELETE, 9'd0,   $urandom);
    send_op(KIND_INSERT, 9'd1,   $urandom);
    send_op(KIND_READ,   9'd511, $urandom);
    send_op(KIND_DELETE, 9'd511, $urandom);
  endtask

  // Head, tail and middle inserts with extreme values, then reads and deletes
  // at head, tail, middle and just past the end.
  task automatic test_head_tail_ops();
    send_op(KIND_INSERT, 9'd0, 32'sh7FFF_FFFF);  // head of empty list
    send_op(KIND_APPEND, 9'd511, 32'sh8000_0000);
    send_op(KIND_INSERT, 9'd2, -32'sd1);         // position == count: tail
    send_op(KIND_INSERT, 9'd1, 32'sd0);
    send_op(KIND_INSERT, 9'd0, 32'sd1);
    send_op(KIND_INSERT, 9'd6, $urandom);        // one past count
    send_op(KIND_INSERT, 9'd511, $urandom);
    for (int p = 0; p <= 5; p++) send_op(KIND_READ, POS_W'(p), $urandom);
    send_op(KIND_READ,   9'd511, $urandom);
    send_op(KIND_DELETE, 9'd4, $urandom);        // tail
    send_op(KIND_DELETE, 9'd0, $urandom);        // head
    send_op(KIND_DELETE, 9'd1, $urandom);        // middle
    send_op(KIND_DELETE, 9'd2, $urandom);        // past end
    send_op(KIND_READ,   9'd0, $urandom);
    send_op(KIND_READ,   9'd1, $urandom);
  endtask

  // Fills to capacity, then pokes the full corner: refusals, the range check
  // taking priority over full, and last-cell read/delete/insert.
  task automatic test_full_store();
    wait_for_outcomes();
    while (shadow_count < CAPACITY)
      send_op(KIND_APPEND, POS_W'($urandom_range(0, 511)), $urandom);
    send_op(KIND_APPEND, 9'd0,   $urandom);
    send_op(KIND_INSERT, 9'd0,   $urandom);
    send_op(KIND_INSERT, 9'd256, $urandom);
    send_op(KIND_INSERT, 9'd257, $urandom);
    send_op(KIND_READ,   9'd255, $urandom);
    send_op(KIND_READ,   9'd256, $urandom);
    send_op(KIND_DELETE, 9'd255, $urandom);
    send_op(KIND_INSERT, 9'd255, 32'sh8000_0000);
    send_op(KIND_READ,   9'd255, $urandom);
  endtask

  // Random op stream. The percentages steer the count up or down; reads take
  // what is left. Most positions land inside the list, some anywhere in 0..511.
  task automatic test_random_ops(input int n_ops, input int ins_pct, input int app_pct,
                                 input int del_pct);
    int                       roll;
    kind_e                    kind;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
    for (int i = 0; i < n_ops; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < ins_pct) kind = KIND_INSERT;
      else if (roll < ins_pct + app_pct) kind = KIND_APPEND;
      else if (roll < ins_pct + app_pct + del_pct) kind = KIND_DELETE;
      else kind = KIND_READ;

      if ($urandom_range(0, 99) < 12) pos = POS_W'($urandom_range(0, 511));
      else if (kind == KIND_INSERT) pos = POS_W'($urandom_range(0, shadow_count));
      else if (shadow_count > 0) pos = POS_W'($urandom_range(0, shadow_count - 1));
      else pos = '0;

      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0:       val = 32'sh7FFF_FFFF;
          1:       val = 32'sh8000_0000;
          2:       val = -32'sd1;
          default: val = 32'sd0;
        endcase
      end else val = $urandom;

      send_op(kind, pos, val);
    end
  endtask

  initial begin
    in_if.valid    <= 1'b0;
    in_if.kind     <= KIND_READ;
    in_if.position <= '0;
    in_if.value    <= '0;
    rst_ni         <= 1'b0;
    error_count    = 0;
    cycle_count    = 0;
    shadow_count   = 0;
    send_idle_en   = 1'b0;
    ready_stall_en = 1'b0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part runs with gaps and stalls on both sides.
    send_idle_en   = 1'b1;
    ready_stall_en = 1'b1;
    test_empty_store();
    test_head_tail_ops();
    test_full_store();

    // Random part: drain from full, grow back, then mixed traffic.
    test_random_ops(120, 10, 5, 50);
    test_random_ops(120, 30, 25, 15);
    test_random_ops(80, 20, 15, 30);
    wait_for_outcomes();
    test_random_ops(80, 20, 15, 30);

    // Closing stretch at full rate: no gaps, no stalls.
    send_idle_en   = 1'b0;
    ready_stall_en = 1'b0;
    test_random_ops(110, 20, 15, 30);

    wait_for_outcomes();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/isu_pkg.sv
hdl/isu_in_if.sv
hdl/isu_out_if.sv
hdl/isu_cell.sv
hdl/isu_rd_tree.sv
hdl/indexed_sequence_store_unit.sv
tb/tb_indexed_sequence_store_unit.sv
